/* hdl/smva_pkg.sv */
// ----------------------------------------------------------------------------
// smva_pkg
// Shared widths, codes and types of the sparse matrix-vector accumulate block.
// ----------------------------------------------------------------------------
package smva_pkg;

  // sizing
  localparam int VERTICES    = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int ADDR_W      = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int IDX_W       = 10;
  localparam int SRC_W       = 32;
  localparam int ACC_W       = 48;
  localparam int PROD_W      = SRC_W + WEIGHT_BITS;
  localparam int SUM_W       = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;

  // request modes
  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_EDGE = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  // controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_ACCUM
  } state_t;

  // one accumulator entry with its saturation flag
  typedef struct packed {
    logic             sat;
    logic [ACC_W-1:0] value;
  } acc_word_t;

  localparam int ACC_WORD_W = $bits(acc_word_t);

  // status from datapath to controller
  typedef struct packed {
    logic go_edge;
    logic go_read;
    logic item_read;
    logic out_free;
  } stat_t;

  // controls from controller to datapath
  typedef struct packed {
    logic              in_stall;
    logic              clear_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              mul_en;
    logic              out_load;
    logic              commit;
  } ctrl_t;

  // index lies inside the vertex range
  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    return (32'(idx) < VERTICES);
  endfunction

endpackage

/* hdl/smva_ram.sv */
// ----------------------------------------------------------------------------
// smva_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smva_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/smva_mac.sv */
// ----------------------------------------------------------------------------
// smva_mac
// Weight multiply with registered product, then saturating accumulate.
// ----------------------------------------------------------------------------
module smva_mac import smva_pkg::*; (
  input  logic                          clk,
  input  logic                          mul_en,
  input  logic signed [SRC_W-1:0]       src_value,
  input  logic signed [WEIGHT_BITS-1:0] weight,
  input  acc_word_t                     acc_in,
  output acc_word_t                     acc_out
);

  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         sum;
  logic [SUM_W-2:ACC_W-1]   sum_hi;
  logic                     ovf_pos;
  logic                     ovf_neg;

  // product register
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= src_value * weight;
    end
  end

  // exact sum, then clamp to the accumulator range
  always_comb begin
    sum     = {{(SUM_W-ACC_W){acc_in.value[ACC_W-1]}}, acc_in.value}
            + {{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    sum_hi  = sum[SUM_W-2:ACC_W-1];
    ovf_pos = !sum[SUM_W-1] && (|sum_hi);
    ovf_neg = sum[SUM_W-1] && !(&sum_hi);
    acc_out.sat = acc_in.sat | ovf_pos | ovf_neg;
    priority if (ovf_pos) begin
      acc_out.value = {1'b0, {(ACC_W-1){1'b1}}};
    end else if (ovf_neg) begin
      acc_out.value = {1'b1, {(ACC_W-1){1'b0}}};
    end else begin
      acc_out.value = sum[ACC_W-1:0];
    end
  end

endmodule

/* hdl/smva_ctrl.sv */
// ----------------------------------------------------------------------------
// smva_ctrl
// Sequencer: clearing pass after reset, then fetch, multiply and commit, or read-out and clear.
// ----------------------------------------------------------------------------
module smva_ctrl import smva_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_last;

  assign clr_last = (clr_addr_r == ADDR_W'(VERTICES - 1));

  // state and clear counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (stat.go_edge || stat.go_read) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (!stat.item_read) begin
          state_nxt = ST_ACCUM;
        end else if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACCUM: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl.in_stall = (state_r != ST_IDLE);
    ctrl.clear_we = (state_r == ST_CLEAR);
    ctrl.clr_addr = clr_addr_r;
    ctrl.mul_en   = (state_r == ST_FETCH) && !stat.item_read;
    ctrl.out_load = (state_r == ST_FETCH) && stat.item_read && stat.out_free;
    ctrl.commit   = (state_r == ST_ACCUM);
  end

endmodule

/* hdl/sparse_matvec_scatter_accumulate_top.sv */
// ----------------------------------------------------------------------------
// sparse_matvec_scatter_accumulate_top
// Edge-stream sparse matrix-vector multiply with saturating accumulators.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the accumulator memory
// and holds in_stall high meanwhile. Then a load, mode 3 or an out-of-range
// edge is taken without leaving idle; an edge passes through memory read,
// registered multiply, accumulate and write back, paced by the read-modify-write
// of the accumulator memory; a read-and-clear reads the entry, then waits
// while the output register still holds an earlier result. One request is
// in flight at a time, and the output register lets the next request enter
// while a result waits to be taken.
module sparse_matvec_scatter_accumulate_top import smva_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [IDX_W-1:0]              in_src_index,
  input  logic [IDX_W-1:0]              in_dst_index,
  input  logic signed [WEIGHT_BITS-1:0] in_edge_weight,
  input  logic signed [SRC_W-1:0]       in_load_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [IDX_W-1:0]              out_index,
  output logic signed [ACC_W-1:0]       out_value,
  output logic                          out_saturated
);

  stat_t stat;
  ctrl_t ctrl;

  logic                          in_accept;
  logic                          in_dst_ok;
  logic                          read_r;
  logic                          dst_ok_r;
  logic [IDX_W-1:0]              dst_r;
  logic signed [WEIGHT_BITS-1:0] weight_r;
  logic [SRC_W-1:0]              src_rd;
  logic [ACC_WORD_W-1:0]         acc_rd_raw;
  acc_word_t                     acc_rd;
  acc_word_t                     acc_new;
  acc_word_t                     acc_wdata;
  logic                          acc_we;
  logic [ADDR_W-1:0]             acc_waddr;
  logic                          src_we;
  logic                          out_valid_r;
  logic [IDX_W-1:0]              out_index_r;
  logic [ACC_W-1:0]              out_value_r;
  logic                          out_sat_r;

  assign in_stall  = ctrl.in_stall;
  assign in_accept = in_valid && !ctrl.in_stall;
  assign in_dst_ok = idx_ok(in_dst_index);

  // status toward the sequencer
  assign stat.go_edge   = in_accept && (in_mode == MODE_EDGE) && in_dst_ok
                        && idx_ok(in_src_index);
  assign stat.go_read   = in_accept && (in_mode == MODE_READ);
  assign stat.item_read = read_r;
  assign stat.out_free  = !out_valid_r || !out_stall;

  smva_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // request fields held while it is in flight
  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_r   <= (in_mode == MODE_READ);
      dst_ok_r <= in_dst_ok;
      dst_r    <= in_dst_index;
      weight_r <= in_edge_weight;
    end
  end

  // source vector memory
  assign src_we = in_accept && (in_mode == MODE_LOAD) && in_dst_ok;

  smva_ram #(
    .DATA_W (SRC_W),
    .DEPTH  (VERTICES),
    .ADDR_W (ADDR_W)
  ) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (ADDR_W'(in_dst_index)),
    .wdata (in_load_value),
    .re    (in_accept),
    .raddr (ADDR_W'(in_src_index)),
    .rdata (src_rd)
  );

  // accumulator memory write select: clear pass, read-and-clear, commit
  always_comb begin
    acc_we    = ctrl.clear_we || (ctrl.out_load && dst_ok_r) || ctrl.commit;
    acc_waddr = ctrl.clear_we ? ctrl.clr_addr : ADDR_W'(dst_r);
    acc_wdata = ctrl.commit ? acc_new : '0;
  end

  smva_ram #(
    .DATA_W (ACC_WORD_W),
    .DEPTH  (VERTICES),
    .ADDR_W (ADDR_W)
  ) u_acc_ram (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (in_accept),
    .raddr (ADDR_W'(in_dst_index)),
    .rdata (acc_rd_raw)
  );

  assign acc_rd = acc_word_t'(acc_rd_raw);

  smva_mac u_mac (
    .clk       (clk),
    .mul_en    (ctrl.mul_en),
    .src_value (src_rd),
    .weight    (weight_r),
    .acc_in    (acc_rd),
    .acc_out   (acc_new)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_index_r <= dst_r;
      out_value_r <= dst_ok_r ? acc_rd.value : '0;
      out_sat_r   <= dst_ok_r && acc_rd.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_saturated = out_sat_r;

endmodule

/* hdl/smva_checker.sv */
// ----------------------------------------------------------------------------
// smva_checker
// Port-level checks of the accumulate block, bound to its top level.
// ----------------------------------------------------------------------------
module smva_checker import smva_pkg::*; (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [1:0]                    in_mode,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [IDX_W-1:0]              out_index,
  input logic signed [ACC_W-1:0]       out_value,
  input logic                          out_saturated
);

  // clearing pass holds off requests right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("no clearing pass after reset");

  // a read request occupies the block in the following cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_mode == MODE_READ)) |=> in_stall)
    else $error("read request did not occupy the block");

  // a new result only comes out of a busy cycle
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_index) && $stable(out_value)
                                  && $stable(out_saturated)))
    else $error("stalled result changed");

endmodule

bind sparse_matvec_scatter_accumulate_top smva_checker u_smva_checker (.*);
